### hdl/sipq_pkg.sv
// Shared types and constants for the sorted insert priority queue.
package sipq_pkg;

    // Width of one stored key.
    localparam int unsigned KEY_W = 64;

    // Width of the reported entry count field.
    localparam int unsigned CNT_OUT_W = 5;

    // Operation requested by an input request.
    typedef enum logic [0:0] {
        ACT_PUSH = 1'b0,
        ACT_POP  = 1'b1
    } t_action;

    // Control broadcast to every cell of the chain.
    typedef struct packed {
        logic             push_en;
        logic             pop_en;
        logic [KEY_W-1:0] key;
    } t_cell_ctl;

endpackage

### hdl/sipq_cell.sv
// One storage cell of the sorted chain: holds one key and shifts with its neighbors.
module sipq_cell
    import sipq_pkg::*;
(
    input  logic             i_clk,
    input  t_cell_ctl        i_ctl,
    input  logic             i_occ,
    input  logic [KEY_W-1:0] i_left_key,
    input  logic             i_left_gt,
    input  logic [KEY_W-1:0] i_right_key,
    output logic [KEY_W-1:0] o_key,
    output logic             o_gt,
    output logic [KEY_W-1:0] o_next_key
);

    logic [KEY_W-1:0] r_key;
    logic [KEY_W-1:0] n_key;

    // A stored key larger than the pushed key has to move one place up.
    assign o_gt = i_occ && (r_key > i_ctl.key);

    // Push: shift in from the left, take the new key at the boundary, or hold.
    // Pop: take the key from the right neighbor.
    always_comb begin
        n_key = r_key;
        if (i_ctl.push_en) begin
            if (i_left_gt) begin
                n_key = i_left_key;
            end else if (o_gt || !i_occ) begin
                n_key = i_ctl.key;
            end
        end else if (i_ctl.pop_en) begin
            n_key = i_right_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    assign o_key      = r_key;
    assign o_next_key = n_key;

endmodule

### hdl/sorted_insert_priority_queue_unit.sv
// Top level of the sorted insert priority queue: cell chain, count and result register.
//
// Usage:
//   The slave stream carries one request per transfer: s_axis_tuser selects
//   push (0) or pop (1), s_axis_tdata carries the key for a push. Each request
//   produces exactly one result on the master stream describing the queue
//   after the operation: head key, empty flag, entry count and overflow.
//   A result follows its request in the next cycle. Throughput is one request
//   per cycle when not stalled: every cell compares its key with the pushed key
//   in parallel, so the whole chain shifts in the same clock edge.
//   A push to a full queue leaves the queue unchanged and reports overflow.
//   A pop from an empty queue is ignored.
//   The result sits in an output register; a new request is taken while
//   that register is empty or being drained in the same cycle, so a stalled
//   receiver stalls the request side after one pending result.
//   Synchronous active-low reset empties the queue and drops any pending
//   result; stored keys are not cleared because only occupied cells are read.
module sorted_insert_priority_queue_unit
    import sipq_pkg::*;
#(
    parameter int unsigned DEPTH = 16
)(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [KEY_W-1:0] s_axis_tdata,  // [63:0] key
    input  logic             s_axis_tuser,  // [0] action
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [71:0]      m_axis_tdata   // [63:0] head_key, [64] is_empty,
                                            // [69:65] entry_count, [70] overflow
);

    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic                  r_out_valid;
    logic [KEY_W-1:0]      r_head;
    logic                  r_empty;
    logic [CNT_OUT_W-1:0]  r_cnt_out;
    logic                  r_ovf;

    logic                  accept;
    logic                  is_full;
    t_action               action;
    t_cell_ctl             ctl;

    logic [KEY_W-1:0]      cell_key  [DEPTH];
    logic [KEY_W-1:0]      cell_next [DEPTH];
    logic                  cell_gt   [DEPTH];
    logic [CW+CNT_OUT_W-1:0] cnt_ext;

    // Request handshake: take a request when the result register can be refilled.
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign action        = t_action'(s_axis_tuser);
    assign is_full       = (r_count == CW'(DEPTH));

    // Broadcast control to the chain.
    always_comb begin
        ctl.key     = s_axis_tdata;
        ctl.push_en = accept && (action == ACT_PUSH) && !is_full;
        ctl.pop_en  = accept && (action == ACT_POP) && (r_count != '0);
    end

    // The chain of cells, entry 0 holding the smallest key.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [KEY_W-1:0] left_key;
        logic             left_gt;
        logic [KEY_W-1:0] right_key;

        if (g == 0) begin : g_first
            assign left_key = s_axis_tdata;
            assign left_gt  = 1'b0;
        end else begin : g_mid
            assign left_key = cell_key[g-1];
            assign left_gt  = cell_gt[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign right_key = cell_key[g];
        end else begin : g_inner
            assign right_key = cell_key[g+1];
        end

        sipq_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_occ       (CW'(g) < r_count),
            .i_left_key  (left_key),
            .i_left_gt   (left_gt),
            .i_right_key (right_key),
            .o_key       (cell_key[g]),
            .o_gt        (cell_gt[g]),
            .o_next_key  (cell_next[g])
        );
    end

    // Occupancy count.
    always_comb begin
        n_count = r_count;
        if (ctl.push_en) begin
            n_count = r_count + CW'(1);
        end else if (ctl.pop_en) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign cnt_ext = {{CNT_OUT_W{1'b0}}, n_count};

    // Result payload describes the queue after the operation.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_head    <= (n_count == '0) ? '0 : cell_next[0];
            r_empty   <= (n_count == '0);
            r_cnt_out <= cnt_ext[CNT_OUT_W-1:0];
            r_ovf     <= (action == ACT_PUSH) && is_full;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_ovf, r_cnt_out, r_empty, r_head};

    // The count never exceeds the number of cells.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    // Overflow is only reported when the queue is full.
    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_ovf) |-> is_full)
        else $error("overflow reported on a queue that is not full");

    // A push to a queue with room grows it by one.
    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (action == ACT_PUSH) && !is_full) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("push did not grow the queue");

    // An empty result carries a zero head key.
    a_empty_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_empty) |-> (r_head == '0))
        else $error("empty result with nonzero head key");

endmodule

### tb/sv/sorted_insert_priority_queue_unit_tb.sv
// Self-checking stream testbench for the sorted insert priority queue.
module sorted_insert_priority_queue_unit_tb;
    import sipq_pkg::*;

    localparam int unsigned QUEUE_DEPTH = 16;
    localparam int unsigned RANDOM_REQUESTS = 550;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned IDLE_PERCENT = 17;
    localparam int unsigned REPORT_LIMIT = 10;

    // One queued request and whether the sender first waits for all results.
    typedef struct {
        t_action          act;
        logic [KEY_W-1:0] key;
        bit               drain_first;
    } t_request;

    // Queue status that one request is expected to report.
    typedef struct {
        logic [KEY_W-1:0]     head_key;
        logic                 is_empty;
        logic [CNT_OUT_W-1:0] entry_count;
        logic                 overflow;
    } t_queue_status;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [KEY_W-1:0] s_axis_tdata = '0;   // [63:0] key
    logic             s_axis_tuser = 1'b0; // [0] action
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [71:0]      m_axis_tdata;        // [63:0] head_key, [64] is_empty,
                                           // [69:65] entry_count, [70] overflow

    // Stimulus backlog, the request on the bus and the expected statuses.
    t_request      request_backlog[$];
    t_request      on_bus;
    t_queue_status pending_status[$];

    // Shadow copy of the sorted key store.
    logic [KEY_W-1:0] shadow_keys[QUEUE_DEPTH];
    int unsigned      shadow_count = 0;

    int unsigned sent_total = 0;
    int unsigned got_total = 0;
    int unsigned cycles = 0;
    int unsigned mismatches = 0;
    int unsigned push_total = 0;
    int unsigned pop_total = 0;
    int unsigned refused_total = 0;
    int unsigned empty_pop_total = 0;
    int unsigned full_total = 0;

    sorted_insert_priority_queue_unit #(
        .DEPTH(QUEUE_DEPTH)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // No idling on either side while this window of requests goes out.
    function automatic bit quiet_window();
        return (sent_total >= 250) && (sent_total < 370);
    endfunction

    // Insert or remove in the shadow store and return the status to expect.
    task automatic apply_request(input t_request req, output t_queue_status st);
        int unsigned pos;
        st.overflow = 1'b0;
        if (req.act == ACT_PUSH) begin
            push_total++;
            if (shadow_count >= QUEUE_DEPTH) begin
                st.overflow = 1'b1;
                refused_total++;
            end else begin
                pos = shadow_count;
                while (pos > 0 && shadow_keys[pos - 1] > req.key) begin
                    shadow_keys[pos] = shadow_keys[pos - 1];
                    pos--;
                end
                shadow_keys[pos] = req.key;
                shadow_count++;
                if (shadow_count == QUEUE_DEPTH) begin
                    full_total++;
                end
            end
        end else begin
            pop_total++;
            if (shadow_count == 0) begin
                empty_pop_total++;
            end else begin
                for (int i = 1; i < shadow_count; i++) begin
                    shadow_keys[i - 1] = shadow_keys[i];
                end
                shadow_count--;
            end
        end
        st.head_key = (shadow_count > 0) ? shadow_keys[0] : '0;
        st.is_empty = (shadow_count == 0);
        st.entry_count = shadow_count[CNT_OUT_W-1:0];
    endtask

    task automatic note_mismatch(input string what, input logic [KEY_W-1:0] want,
                                 input logic [KEY_W-1:0] seen);
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
            $display("mismatch on result %0d: %s expected %h got %h",
                     got_total, what, want, seen);
        end
    endtask

    // Keys drawn from wide random words, a few small values that repeat, edges and shifted words.
    function automatic logic [KEY_W-1:0] pick_key();
        logic [KEY_W-1:0] k;
        case ($urandom_range(3))
            0: k = {$urandom, $urandom};
            1: k = KEY_W'($urandom_range(7));
            2: begin
                case ($urandom_range(2))
                    0: k = '1;
                    1: k = '0;
                    default: k = KEY_W'(1) << $urandom_range(KEY_W - 1);
                endcase
            end
            default: k = {$urandom_range(3), 32'($urandom)} << ($urandom_range(7) * 8);
        endcase
        return k;
    endfunction

    function automatic t_request make_request(input t_action act, input logic [KEY_W-1:0] key);
        t_request r;
        r.act = act;
        r.key = key;
        r.drain_first = 1'b0;
        return r;
    endfunction

    // Request driver: holds a request until taken, otherwise presents the next one or idles.
    always @(posedge i_clk) begin : drive_requests
        t_queue_status st;
        int unsigned   took;
        int unsigned   in_flight;
        bit            idle;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            took = 0;
            if (s_axis_tvalid && s_axis_tready) begin
                apply_request(on_bus, st);
                pending_status.push_back(st);
                took = 1;
                sent_total <= sent_total + 1;
            end
            if (!(s_axis_tvalid && !s_axis_tready)) begin
                in_flight = sent_total + took - got_total;
                idle = !quiet_window() && ($urandom_range(99) < IDLE_PERCENT);
                if (request_backlog.size() > 0 && !idle
                        && !(request_backlog[0].drain_first && in_flight != 0)) begin
                    on_bus = request_backlog.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= on_bus.key;
                    s_axis_tuser <= on_bus.act;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compares each taken result with the oldest expectation.
    always @(posedge i_clk) begin : check_results
        t_queue_status want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got_total <= got_total + 1;
                if (pending_status.size() == 0) begin
                    note_mismatch("unexpected result, tdata", '0, m_axis_tdata[63:0]);
                end else begin
                    want = pending_status.pop_front();
                    if (m_axis_tdata[63:0] !== want.head_key)
                        note_mismatch("head_key", want.head_key, m_axis_tdata[63:0]);
                    if (m_axis_tdata[64] !== want.is_empty)
                        note_mismatch("is_empty", KEY_W'(want.is_empty),
                                      KEY_W'(m_axis_tdata[64]));
                    if (m_axis_tdata[69:65] !== want.entry_count)
                        note_mismatch("entry_count", KEY_W'(want.entry_count),
                                      KEY_W'(m_axis_tdata[69:65]));
                    if (m_axis_tdata[70] !== want.overflow)
                        note_mismatch("overflow", KEY_W'(want.overflow),
                                      KEY_W'(m_axis_tdata[70]));
                end
            end
            m_axis_tready <= quiet_window() || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Stimulus and end of run.
    initial begin : run_sequence
        t_request    r;
        int unsigned phase_left;
        int unsigned push_percent;

        // Directed part: empty pop, extreme keys, equal keys, fill, refused push.
        request_backlog.push_back(make_request(ACT_POP, '1));
        request_backlog.push_back(make_request(ACT_PUSH, '1));
        request_backlog.push_back(make_request(ACT_PUSH, '0));
        request_backlog.push_back(make_request(ACT_PUSH, '0));
        for (int i = 0; i < 12; i++) begin
            request_backlog.push_back(make_request(ACT_PUSH,
                (i % 2 == 0) ? 64'hAAAA_AAAA_AAAA_AAAA >> i : 64'h5555_5555_5555_5555 << i));
        end
        request_backlog.push_back(make_request(ACT_PUSH, 64'h0102_0304_0506_0708));
        request_backlog.push_back(make_request(ACT_PUSH, 64'h8000_0000_0000_0000));
        request_backlog.push_back(make_request(ACT_POP, '0));
        request_backlog.push_back(make_request(ACT_PUSH, '0));
        request_backlog.push_back(make_request(ACT_PUSH, 64'h7FFF_FFFF_FFFF_FFFF));

        // Random part in phases that lean toward filling or draining.
        phase_left = 0;
        push_percent = 50;
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (phase_left == 0) begin
                phase_left = $urandom_range(20, 60);
                case ($urandom_range(3))
                    0: push_percent = 20;
                    1: push_percent = 50;
                    2: push_percent = 80;
                    default: push_percent = 95;
                endcase
            end
            phase_left--;
            r = make_request(($urandom_range(99) < push_percent) ? ACT_PUSH : ACT_POP,
                             pick_key());
            r.drain_first = (n == 0) || (n == 300);
            request_backlog.push_back(r);
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: everything sent and every result back, then a short settle.
        // Sampled on the falling edge so that the driver and monitor updates have settled.
        while (request_backlog.size() > 0 || s_axis_tvalid || got_total != sent_total)
            @(negedge i_clk);
        repeat (4) @(posedge i_clk);
        if (pending_status.size() != 0) begin
            note_mismatch("results never seen, count", '0, KEY_W'(pending_status.size()));
        end

        $display("run: %0d requests, %0d pushes (%0d refused on a full queue), %0d pops",
                 sent_total, push_total, refused_total, pop_total);
        $display("run: %0d pops on an empty queue, queue filled %0d times, %0d mismatches",
                 empty_pop_total, full_total, mismatches);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
